// ----- rtl/fixed_step_audio_resampler_unit_macros.svh -----
// Assertion macros shared by the resampler RTL.
`ifndef FIXED_STEP_AUDIO_RESAMPLER_UNIT_MACROS_SVH
`define FIXED_STEP_AUDIO_RESAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FSAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FSAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fsar_pkg.sv -----
// Shared types and constants for the fixed-step audio resampler.
package fsar_pkg;

  localparam int COUNT_BITS_DEF = 24;  // default width of the sample counters
  localparam int FRAC_BITS      = 8;   // fraction bits of the phase accumulator
  localparam int STEP_W         = 13;  // step register width (5.8 fixed point)
  localparam int CNT_CFG_W      = 24;  // output count register width
  localparam int SAMPLE_W       = 16;
  localparam int MAX_OUT        = 64;  // outputs per source sample at most
  localparam int OUT_N_W        = $clog2(MAX_OUT + 1);
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;

  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_STEP  = 2'd0,
    REG_IN16  = 2'd1,
    REG_OUT16 = 2'd2,
    REG_COUNT = 2'd3
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [STEP_W-1:0]    step;
    logic                 in16;
    logic                 out16;
    logic [CNT_CFG_W-1:0] count;
  } cfg_t;

endpackage

// ----- rtl/fsar_regs.sv -----
// APB-style configuration registers of the resampler.
module fsar_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fsar_pkg::ADDR_W-1:0] paddr,
  input  logic [fsar_pkg::DATA_W-1:0] pwdata,
  output logic [fsar_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output fsar_pkg::cfg_t              cfg
);
  import fsar_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_STEP:  cfg_nxt.step  = pwdata[STEP_W-1:0];
        REG_IN16:  cfg_nxt.in16  = pwdata[0];
        REG_OUT16: cfg_nxt.out16 = pwdata[0];
        REG_COUNT: cfg_nxt.count = pwdata[CNT_CFG_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step  <= STEP_RESET;
      cfg_r.in16  <= 1'b0;
      cfg_r.out16 <= 1'b0;
      cfg_r.count <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read decode
  always_comb begin
    unique case (idx)
      REG_STEP:  prdata = DATA_W'(cfg_r.step);
      REG_IN16:  prdata = DATA_W'(cfg_r.in16);
      REG_OUT16: prdata = DATA_W'(cfg_r.out16);
      REG_COUNT: prdata = DATA_W'(cfg_r.count);
      default:   prdata = '0;
    endcase
  end

endmodule

// ----- rtl/fsar_fmt.sv -----
// Sample format conversion: raw source word to the output sample value.
module fsar_fmt (
  input  logic [fsar_pkg::SAMPLE_W-1:0]        raw,
  input  logic                                 in16,
  input  logic                                 out16,
  output logic signed [fsar_pkg::SAMPLE_W-1:0] value
);
  import fsar_pkg::*;

  logic signed [SAMPLE_W-1:0] src;

  // Unsigned byte b becomes (b - 128) << 8: flip the top bit, pad zeros
  assign src = in16 ? $signed(raw) : $signed({~raw[7], raw[6:0], 8'h00});

  // 8-bit output is the arithmetic shift right by 8, sign-extended
  assign value = out16 ? src : (src >>> 8);

endmodule

// ----- rtl/fixed_step_audio_resampler_unit.sv -----
// Top level of the fixed-step nearest-neighbor audio resampler.
// Takes one mono source sample per transaction (tdata = sample, tuser = start
// of sound) and gives output sample i = source sample (i*step)>>8, with step
// in 5.8 fixed point (values below 4 act as 4), stopping after out_count
// outputs and raising tlast on the last one. A source sample stays in the
// datapath while it still matches, giving one output per cycle while the single
// output register is free (a waiting result with out_tready low holds it), and
// leaves in the cycle that finds no further match, which may also take in
// another sample. A new sample is accepted while the last result still waits
// in the output register. Registers: step at 0x0,
// in_is_16bit at 0x4, out_is_16bit at 0x8, out_count at 0xC; write them only
// while the block is idle. No clearing pass after reset.
`include "fixed_step_audio_resampler_unit_macros.svh"
module fixed_step_audio_resampler_unit #(
  parameter int COUNT_BITS = fsar_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fsar_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [fsar_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [fsar_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fsar_pkg::SAMPLE_W-1:0] in_tdata,   // [15:0] in_sample
  input  logic [0:0]                    in_tuser,   // [0] first
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fsar_pkg::SAMPLE_W-1:0] out_tdata,  // [15:0] out_sample
  output logic                          out_tlast   // last_of_sound
);
  import fsar_pkg::*;

  localparam int PH_W  = COUNT_BITS + FRAC_BITS;
  localparam int CMP_W = (COUNT_BITS > CNT_CFG_W) ? COUNT_BITS : CNT_CFG_W;

  cfg_t cfg;

  // Item under work and its counters
  logic                       active_r, active_nxt;
  logic signed [SAMPLE_W-1:0] val_r, val_nxt;
  logic [PH_W-1:0]            phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]      oidx_r, oidx_nxt;
  logic [COUNT_BITS-1:0]      iidx_r, iidx_nxt;
  logic [OUT_N_W-1:0]         n_r, n_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;

  logic signed [SAMPLE_W-1:0] in_val;
  logic [STEP_W-1:0]          step_eff;
  logic [CMP_W-1:0]           cnt_ext, oidx_ext;
  logic                       match, out_free, emit, done, in_acc, is_last;

  fsar_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  fsar_fmt u_fmt (
    .raw   (in_tdata),
    .in16  (cfg.in16),
    .out16 (cfg.out16),
    .value (in_val)
  );

  // Match test: item active, per-sample cap not reached, sound not finished and the phase points at this sample
  assign step_eff = (cfg.step < STEP_MIN) ? STEP_MIN : cfg.step;
  assign cnt_ext  = CMP_W'(cfg.count);
  assign oidx_ext = CMP_W'(oidx_r);
  assign match    = active_r && (n_r < OUT_N_W'(MAX_OUT)) && (oidx_ext < cnt_ext) &&
                    (phase_r[PH_W-1:FRAC_BITS] == iidx_r);
  assign is_last  = (oidx_ext == (cnt_ext - CMP_W'(1)));

  assign out_free  = !out_valid_r || out_tready;
  assign emit      = match && out_free;
  assign done      = active_r && !match;
  assign in_tready = !match;
  assign in_acc    = in_tvalid && in_tready;

  // Counter and item update
  always_comb begin
    active_nxt = active_r;
    val_nxt    = val_r;
    phase_nxt  = phase_r;
    oidx_nxt   = oidx_r;
    iidx_nxt   = iidx_r;
    n_nxt      = n_r;
    if (emit) begin
      oidx_nxt  = oidx_r + COUNT_BITS'(1);
      phase_nxt = phase_r + PH_W'(step_eff);
      n_nxt     = n_r + OUT_N_W'(1);
    end
    if (done) begin
      iidx_nxt   = iidx_r + COUNT_BITS'(1);
      active_nxt = 1'b0;
    end
    if (in_acc) begin
      active_nxt = 1'b1;
      val_nxt    = in_val;
      n_nxt      = '0;
      // start of a sound clears the counters before the sample is used
      if (in_tuser[0]) begin
        phase_nxt = '0;
        oidx_nxt  = '0;
        iidx_nxt  = '0;
      end
    end
  end

  // Output register load and drain
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = val_r;
      out_last_nxt  = is_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      phase_r     <= '0;
      oidx_r      <= '0;
      iidx_r      <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      oidx_r      <= oidx_nxt;
      iidx_r      <= iidx_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Checks
  `FSAR_ASSERT_NOW(a_emit_in_bounds, emit, (n_r < OUT_N_W'(MAX_OUT)) && (oidx_ext < cnt_ext), "output given past the per-sample cap or the sound end")
  `FSAR_ASSERT_NEXT(a_accept_starts_item, in_acc, active_r && (n_r == '0), "accepted sample not taken into work")
  `FSAR_ASSERT_NEXT(a_emit_loads_output, emit, out_valid_r, "result lost on the way to the output register")

endmodule
